@@ rtl/spsu_pkg.sv @@
package spsu_pkg;

  // Block constants
  localparam int MEAN_FRAMES = 20;
  localparam int BIN_COUNT   = 1024;
  localparam int RING_DEPTH  = 4;

  // Field widths
  localparam int MAG_W     = 32;
  localparam int BIN_W     = 10;
  localparam int BAND_W    = 6;
  localparam int GAIN_W    = 6;
  localparam int SILENT_W  = 8;
  localparam int GATHER_W  = 7;
  localparam int MEAN_W    = 16;
  localparam int ROT_W     = 18;
  localparam int ROT_LIMIT = 77175;

  localparam int RING_PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Mean divide by MEAN_FRAMES+1: one reciprocal multiply, exact for any MEAN_W-bit sum
  localparam int DIV_DIVISOR = MEAN_FRAMES + 1;
  localparam int DIV_SHIFT   = MEAN_W + $clog2(DIV_DIVISOR);
  localparam int DIV_RECIP   = ((1 << DIV_SHIFT) + DIV_DIVISOR - 1) / DIV_DIVISOR;
  localparam int DIV_PROD_W  = MEAN_W + DIV_SHIFT;

  // Steering product widths
  localparam int ERR_W  = MEAN_W + 1;
  localparam int SQ_W   = 2 * MEAN_W;
  localparam int PROD_W = SQ_W + GAIN_W;

  // Stream widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_FIELD_W = ROT_W + 2 + 1 + BIN_W + GATHER_W;

  // Configuration port
  localparam int CFG_COUNT  = 8;
  localparam int APB_ADDR_W = $clog2(CFG_COUNT * 4);
  localparam int APB_DATA_W = 32;

  // Register reset values
  localparam logic [MAG_W-1:0]    RST_THRESHOLD  = MAG_W'(15000);
  localparam logic [BIN_W-1:0]    RST_SCAN_LOW   = BIN_W'(10);
  localparam logic [BIN_W-1:0]    RST_SCAN_HIGH  = BIN_W'(45);
  localparam logic [BIN_W-1:0]    RST_START_LOW  = BIN_W'(17);
  localparam logic [BIN_W-1:0]    RST_START_HIGH = BIN_W'(30);
  localparam logic [BAND_W-1:0]   RST_BAND       = BAND_W'(1);
  localparam logic [GAIN_W-1:0]   RST_GAIN       = GAIN_W'(12);
  localparam logic [SILENT_W-1:0] RST_SILENCE    = SILENT_W'(15);

  typedef enum logic [2:0] {
    REG_THRESHOLD  = 3'd0,
    REG_SCAN_LOW   = 3'd1,
    REG_SCAN_HIGH  = 3'd2,
    REG_START_LOW  = 3'd3,
    REG_START_HIGH = 3'd4,
    REG_BAND       = 3'd5,
    REG_GAIN       = 3'd6,
    REG_SILENCE    = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ANALYSE = 2'd1,
    MODE_MOVE    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DRIVE_NONE = 2'd0,
    DRIVE_MOVE = 2'd1,
    DRIVE_STOP = 2'd2
  } drive_t;

  typedef struct packed {
    logic [MAG_W-1:0]    threshold;
    logic [BIN_W-1:0]    scan_low;
    logic [BIN_W-1:0]    scan_high;
    logic [BIN_W-1:0]    start_low;
    logic [BIN_W-1:0]    start_high;
    logic [BAND_W-1:0]   band;
    logic [GAIN_W-1:0]   gain;
    logic [SILENT_W-1:0] silence;
  } cfg_t;

  typedef struct packed {
    logic scan;
    logic stop;
    logic decide;
    logic div_step;
    logic mul1;
    logic mul2;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_needed;
  } status_t;

  typedef struct packed {
    logic [GATHER_W-1:0]    mean_progress;
    logic [BIN_W-1:0]       peak_bin;
    logic                   peak_found;
    mode_t                  mode_now;
    logic signed [ROT_W-1:0] rotation;
    drive_t                 drive;
  } res_t;

endpackage

@@ rtl/spsu_regs.sv @@
module spsu_regs
  import spsu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_index_t index;
  logic       wr_en;

  assign pready = 1'b1;
  assign index  = reg_index_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold  <= RST_THRESHOLD;
      cfg.scan_low   <= RST_SCAN_LOW;
      cfg.scan_high  <= RST_SCAN_HIGH;
      cfg.start_low  <= RST_START_LOW;
      cfg.start_high <= RST_START_HIGH;
      cfg.band       <= RST_BAND;
      cfg.gain       <= RST_GAIN;
      cfg.silence    <= RST_SILENCE;
    end else if (wr_en) begin
      unique case (index)
        REG_THRESHOLD:  cfg.threshold  <= pwdata[MAG_W-1:0];
        REG_SCAN_LOW:   cfg.scan_low   <= pwdata[BIN_W-1:0];
        REG_SCAN_HIGH:  cfg.scan_high  <= pwdata[BIN_W-1:0];
        REG_START_LOW:  cfg.start_low  <= pwdata[BIN_W-1:0];
        REG_START_HIGH: cfg.start_high <= pwdata[BIN_W-1:0];
        REG_BAND:       cfg.band       <= pwdata[BAND_W-1:0];
        REG_GAIN:       cfg.gain       <= pwdata[GAIN_W-1:0];
        REG_SILENCE:    cfg.silence    <= pwdata[SILENT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_THRESHOLD:  prdata = APB_DATA_W'(cfg.threshold);
      REG_SCAN_LOW:   prdata = APB_DATA_W'(cfg.scan_low);
      REG_SCAN_HIGH:  prdata = APB_DATA_W'(cfg.scan_high);
      REG_START_LOW:  prdata = APB_DATA_W'(cfg.start_low);
      REG_START_HIGH: prdata = APB_DATA_W'(cfg.start_high);
      REG_BAND:       prdata = APB_DATA_W'(cfg.band);
      REG_GAIN:       prdata = APB_DATA_W'(cfg.gain);
      REG_SILENCE:    prdata = APB_DATA_W'(cfg.silence);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ rtl/spsu_ctrl.sv @@
module spsu_ctrl
  import spsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_kind,
  input  logic    in_last,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  status_t st,
  output cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DIV,
    ST_MUL1,
    ST_MUL2,
    ST_PUSH
  } state_t;

  state_t state;
  logic   fire;
  logic   out_free;

  assign in_ready = (state == ST_IDLE);
  assign fire     = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    cmd.scan     = fire & ~in_kind;
    cmd.stop     = fire & in_kind;
    cmd.decide   = (state == ST_DECIDE);
    cmd.div_step = (state == ST_DIV);
    cmd.mul1     = (state == ST_MUL1);
    cmd.mul2     = (state == ST_MUL2);
    cmd.load_out = (state == ST_PUSH) & out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (fire && !in_kind && in_last) state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          state <= st.div_needed ? ST_DIV : ST_MUL1;
        end
        ST_DIV:  state <= ST_MUL1;
        ST_MUL1: state <= ST_MUL2;
        ST_MUL2: state <= ST_PUSH;
        ST_PUSH: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase

      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/spsu_dp.sv @@
module spsu_dp
  import spsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  cmd_t             cmd,
  output status_t          st,
  input  logic [BIN_W-1:0] bin_index,
  input  logic [MAG_W-1:0] magnitude,
  output res_t             res
);

  // scan state
  logic [MAG_W-1:0]      running_max;
  logic                  ring_valid [RING_DEPTH];
  logic [BIN_W-1:0]      ring_bin   [RING_DEPTH];
  logic [RING_PTR_W-1:0] ring_ptr;

  // pilot state
  mode_t                 mode;
  logic [GATHER_W-1:0]   gathered;
  logic [SILENT_W-1:0]   silent;
  logic [MEAN_W-1:0]     mean;

  // per-frame work registers
  logic [BIN_W-1:0]      peak;
  logic                  found;
  logic [MEAN_W-1:0]     div_q;
  logic                  err_neg;
  logic                  over_band;
  logic [SQ_W-1:0]       prod1;
  logic [PROD_W-1:0]     prod2;

  logic                  in_window;
  logic                  is_record;
  logic [RING_PTR_W-1:0] ptr_inc;
  logic                  sel_found;
  logic [BIN_W-1:0]      sel_peak;
  logic [MEAN_W-1:0]     mean_sum;
  logic [SILENT_W-1:0]   silent_inc;
  logic                  in_start;
  logic [DIV_PROD_W-1:0] div_prod;
  logic [MEAN_W-1:0]     div_quot;
  logic [ERR_W-1:0]      err;
  logic [MEAN_W-1:0]     err_mag;
  logic                  moving;
  logic [ROT_W-1:0]      rot_mag;

  assign in_window = (bin_index >= cfg.scan_low) && (bin_index <= cfg.scan_high) &&
                     (32'(bin_index) < 32'(BIN_COUNT));
  assign is_record = in_window && (magnitude > running_max);
  assign ptr_inc   = (ring_ptr == RING_PTR_W'(RING_DEPTH - 1)) ? '0 : ring_ptr + 1'b1;

  // oldest record sits at the write pointer once the ring has wrapped
  always_comb begin
    if (ring_valid[ring_ptr]) begin
      sel_found = 1'b1;
      sel_peak  = ring_bin[ring_ptr];
    end else if (ring_valid[0]) begin
      sel_found = 1'b1;
      sel_peak  = ring_bin[0];
    end else begin
      sel_found = 1'b0;
      sel_peak  = '0;
    end
  end

  assign mean_sum   = mean + MEAN_W'(sel_peak);
  assign silent_inc = silent + 1'b1;
  assign in_start   = (sel_peak > cfg.start_low) && (sel_peak < cfg.start_high);

  assign st.div_needed = sel_found && (gathered == GATHER_W'(MEAN_FRAMES));

  // truncating divide of the final sum by MEAN_FRAMES+1
  assign div_prod = DIV_PROD_W'(div_q) * DIV_PROD_W'(DIV_RECIP);
  assign div_quot = div_prod[DIV_SHIFT +: MEAN_W];

  assign err     = ERR_W'(peak) - ERR_W'(mean);
  assign err_mag = err[ERR_W-1] ? MEAN_W'(-err) : err[MEAN_W-1:0];

  assign moving  = (mode == MODE_MOVE) && (silent == '0);
  assign rot_mag = (prod2 > PROD_W'(ROT_LIMIT)) ? ROT_W'(ROT_LIMIT) : prod2[ROT_W-1:0];

  // control and pilot state
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max <= RST_THRESHOLD;
      ring_ptr    <= '0;
      mode        <= MODE_OFF;
      gathered    <= '0;
      silent      <= '0;
      mean        <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_valid[i] <= 1'b0;
    end else begin
      if (cmd.scan && is_record) begin
        running_max          <= magnitude;
        ring_valid[ring_ptr] <= 1'b1;
        ring_ptr             <= ptr_inc;
      end

      if (cmd.stop || cmd.decide) begin
        running_max <= cfg.threshold;
        ring_ptr    <= '0;
        for (int i = 0; i < RING_DEPTH; i++) ring_valid[i] <= 1'b0;
      end

      if (cmd.stop) begin
        mode     <= MODE_OFF;
        gathered <= '0;
        silent   <= '0;
      end

      if (cmd.decide) begin
        if (!sel_found) begin
          if (mode != MODE_OFF) begin
            silent <= silent_inc;
            if (silent_inc == cfg.silence) begin
              mean     <= '0;
              gathered <= '0;
              mode     <= MODE_OFF;
            end
          end
        end else begin
          silent <= '0;
          if (gathered == '0) begin
            if (in_start) begin
              mean     <= MEAN_W'(sel_peak);
              mode     <= MODE_ANALYSE;
              gathered <= GATHER_W'(1);
            end
          end else if (gathered <= GATHER_W'(MEAN_FRAMES)) begin
            // final sum goes through the divide step, mean written there
            if (gathered != GATHER_W'(MEAN_FRAMES)) mean <= mean_sum;
            mode     <= MODE_ANALYSE;
            gathered <= gathered + 1'b1;
          end else begin
            mode <= MODE_MOVE;
          end
        end
      end

      if (cmd.div_step) mean <= div_quot;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.scan && is_record) ring_bin[ring_ptr] <= bin_index;

    if (cmd.decide) begin
      peak  <= sel_peak;
      found <= sel_found;
      div_q <= mean_sum;
    end

    if (cmd.mul1) begin
      err_neg   <= err[ERR_W-1];
      over_band <= err_mag > MEAN_W'(cfg.band);
      prod1     <= err_mag * err_mag;
    end

    if (cmd.mul2) prod2 <= prod1 * PROD_W'(cfg.gain);

    if (cmd.load_out) begin
      res.mean_progress <= gathered;
      res.peak_bin      <= peak;
      res.peak_found    <= found;
      res.mode_now      <= mode;
      if (moving) begin
        res.drive <= DRIVE_MOVE;
      end else if (mode == MODE_OFF || mode == MODE_MOVE) begin
        res.drive <= DRIVE_STOP;
      end else begin
        res.drive <= DRIVE_NONE;
      end
      if (moving && over_band) begin
        res.rotation <= err_neg ? -$signed(rot_mag) : $signed(rot_mag);
      end else begin
        res.rotation <= '0;
      end
    end
  end

endmodule

@@ rtl/spectral_pitch_steering_unit.sv @@
// Spectral pitch steering unit.
//
// Spectrum bins come in on the s_ stream, one word per bin in ascending bin
// order; s_tlast marks the last bin of a frame and s_tuser = 1 marks a stop
// word that clears the mode and frame counters. Each frame's last bin makes
// one result word on the m_ stream: drive command, signed rotation, mode,
// peak flag, peak bin and mean progress. Other words make no result.
//
// Non-final bins and stop words are taken whenever the block is idle. After
// a last bin is accepted it steps through decide, square, gain and output
// load with s_tready low; m_tvalid rises and s_tready returns high after the
// output load. The frame that completes the mean adds a reciprocal-multiply
// step after decide that divides by MEAN_FRAMES+1. If the receiver stalls,
// the finished word waits in the output register and bins keep flowing; the
// next frame end holds in its output-load step until the register is free.
// Reset puts the block in sound-off mode with empty counters and loads the
// register defaults. Registers are to be written over the APB port between
// words by the user; the block itself does not enforce it.
module spectral_pitch_steering_unit
  import spsu_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // APB configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready,
  // bin input
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // bin_index[9:0], magnitude[41:10]
  input  logic                   s_tuser,  // kind
  input  logic                   s_tlast,  // last_bin
  // result output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // rotation, mode_now, peak_found,
                                           // peak_bin, mean_progress
  output logic [1:0]             m_tuser   // drive
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t st;
  res_t    res;

  spsu_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .st        (st),
    .cmd       (cmd)
  );

  spsu_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .st        (st),
    .bin_index (s_tdata[BIN_W-1:0]),
    .magnitude (s_tdata[BIN_W+MAG_W-1:BIN_W]),
    .res       (res)
  );

  assign m_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), res.mean_progress, res.peak_bin,
                    res.peak_found, res.mode_now, res.rotation};
  assign m_tuser = res.drive;

  // a result only comes out of the frame-end sequence, never straight from idle
  a_result_from_sequence: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared without a frame-end sequence");

  a_move_needs_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.drive == DRIVE_MOVE) |-> (res.mode_now == MODE_MOVE))
    else $error("move command outside moving mode");

  a_rotation_only_on_move: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.rotation != '0) |-> (res.drive == DRIVE_MOVE))
    else $error("nonzero rotation without move command");

  a_no_peak_zero_bin: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.peak_found) |-> (res.peak_bin == '0))
    else $error("peak bin set without a peak");

endmodule
